FILE: rtl/core/binary_to_decimal_ascii_unit_defines.svh
// assertion macros for the binary to decimal ascii unit
// used by the top level only; no other dependencies
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define B2DA_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("b2da assertion failed");
`define B2DA_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("b2da assertion failed");
`else
`define B2DA_ASSERT_SAME(label, clk, rst_n, a, b)
`define B2DA_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/core/b2da_pkg.sv
// shared types and constants of the binary to decimal ascii unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package b2da_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_DIGITS      = 10;
    localparam logic [63:0] MAX_DEC_VALUE = 64'd9999999999;
    localparam logic [5:0]  ASCII_ZERO    = 6'd48;

    typedef logic [3:0] bcd_t;
    typedef logic [3:0] dcount_t;

    typedef struct packed {
        logic load;
        logic bit_shift;
        logic digit_shift;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_ALIGN,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/b2da_cell.sv
// one bcd digit cell: add-3 and shift during conversion, digit move during output
// depends on b2da_pkg
`timescale 1ns / 1ps
`default_nettype none
module b2da_cell (
    input  wire                  clk,
    input  b2da_pkg::cell_ctl_t  ctl,
    input  wire                  bit_in,
    input  b2da_pkg::bcd_t       digit_in,
    output b2da_pkg::bcd_t       digit,
    output logic                 carry_out
);
    import b2da_pkg::*;

    bcd_t digit_reg;
    bcd_t digit_next;
    bcd_t adj;

    always_comb
    begin
        adj = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.load)
        begin
            digit_next = '0;
        end
        else if (ctl.bit_shift)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (ctl.digit_shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit     = digit_reg;
    assign carry_out = adj[3];

endmodule
`default_nettype wire

FILE: rtl/core/b2da_row.sv
// row of bcd digit cells, least significant digit in cell 0
// depends on b2da_pkg and b2da_cell
`timescale 1ns / 1ps
`default_nettype none
module b2da_row (
    input  wire                  clk,
    input  b2da_pkg::cell_ctl_t  ctl,
    input  wire                  bit_in,
    output b2da_pkg::bcd_t       top_digit,
    output b2da_pkg::dcount_t    count
);
    import b2da_pkg::*;

    bcd_t [MAX_DIGITS-1:0] digits;
    logic [MAX_DIGITS-1:0] carries;

    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                b2da_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctl),
                    .bit_in    (bit_in),
                    .digit_in  ('0),
                    .digit     (digits[g]),
                    .carry_out (carries[g])
                );
            end
            else
            begin : g_rest
                b2da_cell u_cell (
                    .clk       (clk),
                    .ctl       (ctl),
                    .bit_in    (carries[g-1]),
                    .digit_in  (digits[g-1]),
                    .digit     (digits[g]),
                    .carry_out (carries[g])
                );
            end
        end
    endgenerate

    // highest nonzero cell gives the digit count
    always_comb
    begin
        count = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (digits[i] != '0)
            begin
                count = 4'(i + 1);
            end
        end
    end

    assign top_digit = digits[MAX_DIGITS-1];

endmodule
`default_nettype wire

FILE: rtl/core/binary_to_decimal_ascii_unit.sv
// binary to decimal ascii converter, top level with sequencer and output register
// depends on b2da_pkg, b2da_row, binary_to_decimal_ascii_unit_defines.svh
//
//  channel | dir | tdata fields (low bit up)                       | tlast
//  s_*     | in  | value [VALUE_WIDTH]                             | -
//  m_*     | out | digit_char[6] digit_valid[1] digit_count[4]     | is_last
//
// one item at a time: a load step, double-dabble shifts of the value through the
// digit cell row, a count step, alignment (10-n shifts bring the leading digit
// to the top cell) and one output per digit for n digits; a value of zero gives a
// single output with digit_valid low
// the result stream stalls on m_tready without losing the row contents
// rst_n clears the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_unit_defines.svh"
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // value
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [15:0]                           m_tdata,  // digit_char, digit_valid, digit_count
    output logic                                  m_tlast   // is_last
);
    import b2da_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    state_t state_reg, state_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    dcount_t                count_reg, count_next;
    dcount_t                remain_reg, remain_next;

    logic       m_tvalid_reg, m_tvalid_next;
    logic [5:0] char_reg, char_next;
    logic       dvalid_reg, dvalid_next;
    dcount_t    dcnt_reg, dcnt_next;
    logic       last_reg, last_next;

    cell_ctl_t  ctl;
    bcd_t       top_digit;
    dcount_t    row_count;
    logic       out_free;
    logic       emit_fire;
    logic       align_done;
    logic       accept;
    logic [VALUE_WIDTH-1:0] value_in;
    logic [VALUE_WIDTH-1:0] value_sat;

    b2da_row u_row (
        .clk       (clk),
        .ctl       (ctl),
        .bit_in    (value_reg[VALUE_WIDTH-1]),
        .top_digit (top_digit),
        .count     (row_count)
    );

    assign value_in = s_tdata[VALUE_WIDTH-1:0];
    // wide values clamp to ten nines
    assign value_sat = (64'(value_in) > MAX_DEC_VALUE) ? VALUE_WIDTH'(MAX_DEC_VALUE) : value_in;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign align_done = (top_digit != '0) || (count_reg == '0);
    assign accept     = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (align_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (remain_reg <= 4'd1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready        = 1'b0;
        ctl             = '0;
        emit_fire       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ctl.load = s_tvalid;
            end
            ST_CONV:
            begin
                ctl.bit_shift = 1'b1;
            end
            ST_COUNT:
            begin
            end
            ST_ALIGN:
            begin
                ctl.digit_shift = !align_done;
            end
            ST_EMIT:
            begin
                emit_fire       = out_free;
                ctl.digit_shift = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        value_next    = value_reg;
        bit_cnt_next  = bit_cnt_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        m_tvalid_next = m_tvalid_reg;
        char_next     = char_reg;
        dvalid_next   = dvalid_reg;
        dcnt_next     = dcnt_reg;
        last_next     = last_reg;

        if (accept)
        begin
            value_next   = value_sat;
            bit_cnt_next = CNT_W'(VALUE_WIDTH);
        end
        else if (state_reg == ST_CONV)
        begin
            value_next   = {value_reg[VALUE_WIDTH-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
        end

        if (state_reg == ST_COUNT)
        begin
            count_next  = row_count;
            remain_next = row_count;
        end

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (emit_fire)
        begin
            m_tvalid_next = 1'b1;
            dvalid_next   = (count_reg != '0);
            char_next     = (count_reg != '0) ? (ASCII_ZERO + {2'b00, top_digit}) : '0;
            dcnt_next     = count_reg;
            last_next     = (remain_reg <= 4'd1);
            if (remain_reg != '0)
            begin
                remain_next = remain_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            count_reg    <= '0;
            remain_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            count_reg    <= count_next;
            remain_reg   <= remain_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        char_reg   <= char_next;
        dvalid_reg <= dvalid_next;
        dcnt_reg   <= dcnt_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, dcnt_reg, dvalid_reg, char_reg};
    assign m_tlast  = last_reg;

    `B2DA_ASSERT_NEXT(a_accept_conv, clk, rst_n, accept, state_reg == ST_CONV)
    `B2DA_ASSERT_NEXT(a_last_idle, clk, rst_n, emit_fire && (remain_reg <= 4'd1), state_reg == ST_IDLE)
    `B2DA_ASSERT_SAME(a_empty_item, clk, rst_n, m_tvalid && !m_tdata[6], m_tlast && (m_tdata[10:7] == 4'd0))

endmodule
`default_nettype wire
